// ===== rtl/otq_pkg.sv =====
package otq_pkg;

    // Width of the id field on the ports.
    localparam int IdW = 16;

    // Request codes carried in the input tuser.
    localparam logic [1:0] FUNC_ENQ     = 2'd0;
    localparam logic [1:0] FUNC_DEQ_ANY = 2'd1;
    localparam logic [1:0] FUNC_DEQ_DOG = 2'd2;
    localparam logic [1:0] FUNC_DEQ_CAT = 2'd3;

    // Result status codes carried in the output tuser.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Class codes.
    localparam logic CLASS_CAT = 1'b0;
    localparam logic CLASS_DOG = 1'b1;

    // Pointer update commands for one FIFO.
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_cmd_t;

    // Occupancy flags of one FIFO.
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_flags_t;

    // One result item.
    typedef struct packed {
        logic [1:0]     status;
        logic [IdW-1:0] id;
        logic           cls;
    } result_t;

endpackage

// ===== rtl/otq_ram.sv =====
module otq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data is registered and holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/otq_ptr.sv =====
module otq_ptr #(
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  otq_pkg::fifo_cmd_t       cmd,
    output logic [$clog2(DEPTH)-1:0] head,
    output logic [$clog2(DEPTH)-1:0] tail,
    output otq_pkg::fifo_flags_t     flags
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tail_next  = wrap_inc(tail_reg);
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            head_next  = wrap_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head        = head_reg;
    assign tail        = tail_reg;
    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_reg == CW'(DEPTH));

endmodule

// ===== rtl/two_class_oldest_first_queue.sv =====
// Two-class oldest-first queue.
//
// The block keeps one FIFO of arrival ids per class (cat and dog), each held
// in its own synchronous memory. Requests arrive on the s_axis channel: the
// tuser carries the request code and the class, the tdata the id. Every
// request yields exactly one result transfer on the m_axis channel: the
// tuser carries the status and the class of the removed entry, the tdata
// the removed id. A dequeue of any class removes the head with the smaller
// id, and the cat head wins a tie.
//
// For each request, both head entries are read from the memories in the
// transfer cycle, and in the execute step the registered head data is
// compared, the pointers are updated and the result is loaded into the
// output register. The block takes no new request until the execute step of
// the last one has completed. If the receiver stalls, the result is held in
// the output register and the block still accepts the next request; that
// request waits in its execute step until the output register frees. Reset
// clears the pointers and counts, so both FIFOs come up empty; the memory
// contents need no clearing.
module two_class_oldest_first_queue #(
    parameter int QUEUE_DEPTH = 256,
    parameter int ID_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] item_id
    input  logic [15:0] s_axis_tdata,
    // [1:0] func, [2] item_class
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] out_id
    output logic [15:0] m_axis_tdata,
    // [1:0] status, [2] out_class
    output logic [2:0]  m_axis_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    // Stored id width: ids keep only ID_BITS bits, and never more than the port.
    localparam int SW = (ID_BITS < otq_pkg::IdW) ? ID_BITS : otq_pkg::IdW;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;

    // Request captured at the input transfer.
    logic [1:0]    func_reg;
    logic [SW-1:0] id_reg;
    logic          cls_reg;

    logic              m_valid_reg, m_valid_next;
    otq_pkg::result_t  res_reg, res_next;

    otq_pkg::fifo_cmd_t   cat_cmd, dog_cmd;
    otq_pkg::fifo_flags_t cat_flags, dog_flags;
    logic [AW-1:0]        cat_head, cat_tail, dog_head, dog_tail;
    logic [SW-1:0]        cat_rdata, dog_rdata;

    logic in_fire;
    logic exec_fire;
    logic take_cat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    // The execute step completes only when the output register can take the result.
    assign exec_fire     = (state_reg == ST_EXEC) && (!m_valid_reg || m_axis_tready);

    otq_ptr #(.DEPTH(QUEUE_DEPTH)) u_cat_ptr (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cat_cmd),
        .head  (cat_head),
        .tail  (cat_tail),
        .flags (cat_flags)
    );

    otq_ptr #(.DEPTH(QUEUE_DEPTH)) u_dog_ptr (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dog_cmd),
        .head  (dog_head),
        .tail  (dog_tail),
        .flags (dog_flags)
    );

    // Heads are read in the transfer cycle; writes happen only in the execute
    // step, so a read never overlaps a write of the same request.
    otq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(SW)) u_cat_ram (
        .clk   (clk),
        .we    (cat_cmd.push),
        .waddr (cat_tail),
        .wdata (id_reg),
        .re    (in_fire),
        .raddr (cat_head),
        .rdata (cat_rdata)
    );

    otq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(SW)) u_dog_ram (
        .clk   (clk),
        .we    (dog_cmd.push),
        .waddr (dog_tail),
        .wdata (id_reg),
        .re    (in_fire),
        .raddr (dog_head),
        .rdata (dog_rdata)
    );

    // Oldest-first choice for a dequeue of any class.
    always_comb
    begin
        if (dog_flags.empty)
        begin
            take_cat = 1'b1;
        end
        else if (cat_flags.empty)
        begin
            take_cat = 1'b0;
        end
        else
        begin
            take_cat = (cat_rdata <= dog_rdata);
        end
    end

    // Execute step: decide the result and the pointer updates.
    always_comb
    begin
        cat_cmd         = '0;
        dog_cmd         = '0;
        res_next.status = otq_pkg::STATUS_OK;
        res_next.id     = '0;
        res_next.cls    = otq_pkg::CLASS_CAT;
        case (func_reg)
            otq_pkg::FUNC_ENQ:
            begin
                if (cls_reg == otq_pkg::CLASS_DOG)
                begin
                    if (dog_flags.full)
                    begin
                        res_next.status = otq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        dog_cmd.push = exec_fire;
                    end
                end
                else
                begin
                    if (cat_flags.full)
                    begin
                        res_next.status = otq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cat_cmd.push = exec_fire;
                    end
                end
            end
            otq_pkg::FUNC_DEQ_ANY:
            begin
                if (cat_flags.empty && dog_flags.empty)
                begin
                    res_next.status = otq_pkg::STATUS_EMPTY;
                end
                else if (take_cat)
                begin
                    cat_cmd.pop = exec_fire;
                    res_next.id = otq_pkg::IdW'(cat_rdata);
                end
                else
                begin
                    dog_cmd.pop  = exec_fire;
                    res_next.id  = otq_pkg::IdW'(dog_rdata);
                    res_next.cls = otq_pkg::CLASS_DOG;
                end
            end
            otq_pkg::FUNC_DEQ_DOG:
            begin
                if (dog_flags.empty)
                begin
                    res_next.status = otq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    dog_cmd.pop  = exec_fire;
                    res_next.id  = otq_pkg::IdW'(dog_rdata);
                    res_next.cls = otq_pkg::CLASS_DOG;
                end
            end
            default:
            begin
                if (cat_flags.empty)
                begin
                    res_next.status = otq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    cat_cmd.pop = exec_fire;
                    res_next.id = otq_pkg::IdW'(cat_rdata);
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (exec_fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= s_axis_tuser[1:0];
            id_reg   <= s_axis_tdata[SW-1:0];
            cls_reg  <= s_axis_tuser[2];
        end
        if (exec_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = res_reg.id;
    assign m_axis_tuser  = {res_reg.cls, res_reg.status};

    // An accepted request always moves on to its execute step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("request transfer not followed by execute step");

    // A FIFO can never be empty and full at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cat_flags.empty && cat_flags.full) && !(dog_flags.empty && dog_flags.full))
        else $error("FIFO flags inconsistent");

    // A result that is not ok carries a zero id and the cat class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (res_reg.status != otq_pkg::STATUS_OK))
            |-> ((res_reg.id == '0) && (res_reg.cls == otq_pkg::CLASS_CAT)))
        else $error("failed request carries a nonzero payload");

endmodule

// ===== test/two_class_oldest_first_queue_tb.sv =====
module two_class_oldest_first_queue_tb;

    // Width of the id field on the ports.
    localparam int IW = otq_pkg::IdW;

    // Capacity of each class FIFO in the block as instantiated.
    localparam int DEPTH = 256;

    // The receiver holds m_axis_tready low once, for this many cycles, after
    // this many results have been taken. That fills the output register and
    // the pending request, so the block has to drop s_axis_tready.
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 600;

    // Cycles without any transfer on either side before the run is abandoned.
    // This is well above the long hold and the longest random gap.
    localparam int IDLE_LIMIT = 4000;

    // Cycles allowed after the last expected result for stray transfers.
    localparam int DRAIN_CYCLES = 20;

    // One request as the sender sees it.
    typedef struct packed {
        logic [1:0]    func;
        logic [IW-1:0] id;
        logic          cls;
    } shelter_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] item_id
    logic [15:0] s_axis_tdata = '0;
    // [1:0] func, [2] item_class
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] out_id
    logic [15:0] m_axis_tdata;
    // [1:0] status, [2] out_class
    logic [2:0]  m_axis_tuser;

    // Requests still to be offered, filled once before reset is released.
    shelter_req_t req_q[$];
    int           total_items;

    // Predicted contents of the two class FIFOs, oldest entry first.
    logic [IW-1:0] cat_line[$];
    logic [IW-1:0] dog_line[$];

    // Results predicted at request time and not yet seen on m_axis.
    otq_pkg::result_t pending_results[$];

    int          accepted_cnt = 0;
    int          results_seen = 0;
    int          err_cnt = 0;
    int          idle_cnt = 0;
    logic [31:0] cyc = '0;

    // Driver-side state.
    shelter_req_t cur_req = '0;
    int           tx_wait = 0;

    // Receiver-side state.
    int rx_wait = 0;
    bit hold_done = 1'b0;

    // Running id for well-formed arrivals, so that ids mostly rise.
    logic [IW-1:0] next_arrival = '0;

    two_class_oldest_first_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Works out the result of one accepted request and advances the
    // predicted FIFO contents. A full FIFO drops the enqueue, an empty one
    // reports empty, and on a dequeue of any class the smaller head id wins
    // with the cat head taking a tie.
    function automatic void shelter_step(input shelter_req_t req);
        otq_pkg::result_t res;
        bit               take_cat;
        res = '0;
        case (req.func)
            otq_pkg::FUNC_ENQ:
            begin
                if (req.cls == otq_pkg::CLASS_DOG)
                begin
                    if (dog_line.size() >= DEPTH)
                        res.status = otq_pkg::STATUS_FULL;
                    else
                        dog_line.push_back(req.id);
                end
                else
                begin
                    if (cat_line.size() >= DEPTH)
                        res.status = otq_pkg::STATUS_FULL;
                    else
                        cat_line.push_back(req.id);
                end
            end
            otq_pkg::FUNC_DEQ_ANY:
            begin
                if (cat_line.size() == 0 && dog_line.size() == 0)
                    res.status = otq_pkg::STATUS_EMPTY;
                else
                begin
                    if (cat_line.size() == 0)
                        take_cat = 1'b0;
                    else if (dog_line.size() == 0)
                        take_cat = 1'b1;
                    else
                        take_cat = (cat_line[0] <= dog_line[0]);
                    if (take_cat)
                    begin
                        res.id  = cat_line[0];
                        res.cls = otq_pkg::CLASS_CAT;
                        cat_line.delete(0);
                    end
                    else
                    begin
                        res.id  = dog_line[0];
                        res.cls = otq_pkg::CLASS_DOG;
                        dog_line.delete(0);
                    end
                end
            end
            otq_pkg::FUNC_DEQ_DOG:
            begin
                if (dog_line.size() == 0)
                    res.status = otq_pkg::STATUS_EMPTY;
                else
                begin
                    res.id  = dog_line[0];
                    res.cls = otq_pkg::CLASS_DOG;
                    dog_line.delete(0);
                end
            end
            default:
            begin
                if (cat_line.size() == 0)
                    res.status = otq_pkg::STATUS_EMPTY;
                else
                begin
                    res.id  = cat_line[0];
                    res.cls = otq_pkg::CLASS_CAT;
                    cat_line.delete(0);
                end
            end
        endcase
        pending_results.push_back(res);
    endfunction

    // Random idle length: mostly none, sometimes a few cycles, rarely a long
    // stretch. During a calm window there is no idling at all.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_req(input logic [1:0] func, input logic [IW-1:0] id,
                           input logic cls);
        shelter_req_t req;
        req.func = func;
        req.id   = id;
        req.cls  = cls;
        req_q.push_back(req);
    endtask

    // Adds one arrival, or a pair of arrivals with the same id in both
    // classes so that equal heads come up. Now and then the id is random
    // over the whole range, which also breaks the rising order.
    task automatic add_arrival();
        int            r;
        logic [IW-1:0] id;
        r = $urandom_range(0, 99);
        if (r < 10)
            id = IW'($urandom);
        else
        begin
            next_arrival = next_arrival + IW'($urandom_range(0, 2));
            id = next_arrival;
        end
        if (r >= 10 && r < 30)
        begin
            add_req(otq_pkg::FUNC_ENQ, id, otq_pkg::CLASS_CAT);
            add_req(otq_pkg::FUNC_ENQ, id, otq_pkg::CLASS_DOG);
        end
        else
            add_req(otq_pkg::FUNC_ENQ, id, 1'($urandom_range(0, 1)));
    endtask

    // A dequeue of a random kind; the id and class bits it carries are
    // ignored by the block but still toggled.
    task automatic add_removal();
        logic [1:0] func;
        case ($urandom_range(0, 2))
            0:       func = otq_pkg::FUNC_DEQ_ANY;
            1:       func = otq_pkg::FUNC_DEQ_DOG;
            default: func = otq_pkg::FUNC_DEQ_CAT;
        endcase
        add_req(func, IW'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // A run of requests in which enq_pct percent are arrivals.
    task automatic add_segment(input int len, input int enq_pct);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < enq_pct)
                add_arrival();
            else
                add_removal();
        end
    endtask

    // Sender. A transfer happens at an edge where s_axis_tvalid and
    // s_axis_tready were both high; the request is then predicted, a gap is
    // drawn, and the next request is put up once the gap has run out. The
    // valid is assigned once per edge, so back-to-back requests keep it high.
    always @(posedge clk or negedge rst_n)
    begin : sender
        bit busy;
        int wait_n;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            tx_wait       <= 0;
        end
        else
        begin
            busy   = s_axis_tvalid;
            wait_n = tx_wait;
            if (s_axis_tvalid && s_axis_tready)
            begin
                shelter_step(cur_req);
                accepted_cnt++;
                busy   = 1'b0;
                wait_n = pick_gap(cyc[9:8] == 2'd0);
            end
            if (!busy)
            begin
                if (wait_n > 0)
                    wait_n--;
                else if (req_q.size() != 0)
                begin
                    cur_req = req_q[0];
                    req_q.delete(0);
                    busy    = 1'b1;
                end
            end
            s_axis_tvalid <= busy;
            s_axis_tdata  <= cur_req.id;
            s_axis_tuser  <= {cur_req.cls, cur_req.func};
            tx_wait       <= wait_n;
        end
    end

    // Receiver and checker. Each result transfer is compared field by field
    // with the oldest predicted result. After a transfer the ready may drop
    // for a random gap; once in the run it drops for the long hold.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        otq_pkg::result_t want;
        int               wait_n;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end
        else
        begin
            wait_n = rx_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding: %s %0d %0d %0d",
                           "status, id, class", m_axis_tuser[1:0], m_axis_tdata,
                           m_axis_tuser[2]);
                    err_cnt++;
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (m_axis_tuser[1:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser[1:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata !== want.id)
                    begin
                        $error("out_id: expected %0d, got %0d", want.id, m_axis_tdata);
                        err_cnt++;
                    end
                    if (m_axis_tuser[2] !== want.cls)
                    begin
                        $error("out_class: expected %0d, got %0d", want.cls, m_axis_tuser[2]);
                        err_cnt++;
                    end
                end
                if (!hold_done && results_seen == HOLD_AT)
                begin
                    hold_done = 1'b1;
                    wait_n    = HOLD_CYCLES;
                end
                else
                    wait_n = pick_gap(cyc[10:9] == 2'd1);
            end
            if (wait_n > 0)
            begin
                wait_n--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
            rx_wait <= wait_n;
        end
    end

    // Watchdog: ends the run when no transfer has happened on either side for
    // too long.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cnt <= 0;
            else if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
            else
                idle_cnt <= idle_cnt + 1;
        end
    end

    initial
    begin
        // Directed part: empty requests of every kind, the id extremes, a
        // smaller dog head beating the cat head, equal heads going to the cat
        // FIFO, and dequeues that carry nonzero id and class bits.
        add_req(otq_pkg::FUNC_DEQ_ANY, 16'h0000, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_DEQ_DOG, 16'hFFFF, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_DEQ_CAT, 16'hFFFF, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_ENQ, 16'hFFFF, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_ENQ, 16'h0000, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_DEQ_ANY, 16'h5A5A, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_DEQ_ANY, 16'hA5A5, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_DEQ_ANY, 16'hFFFF, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_ENQ, 16'h0007, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_ENQ, 16'h0007, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_DEQ_ANY, 16'h0000, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_DEQ_ANY, 16'h0000, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_ENQ, 16'h1234, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_DEQ_CAT, 16'h0000, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_DEQ_DOG, 16'h0000, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_ENQ, 16'hA5A5, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_ENQ, 16'h5A5A, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_DEQ_DOG, 16'h0000, otq_pkg::CLASS_CAT);
        add_req(otq_pkg::FUNC_DEQ_CAT, 16'h0000, otq_pkg::CLASS_DOG);
        add_req(otq_pkg::FUNC_DEQ_DOG, 16'h0000, otq_pkg::CLASS_DOG);

        // Random part. First a run that is nearly all arrivals, long enough to
        // overfill both class FIFOs, then a draining run that empties them,
        // then runs of mixed shape.
        add_segment(620, 95);
        add_segment(620, 8);
        while (req_q.size() < 1820)
            add_segment($urandom_range(30, 150), $urandom_range(15, 85));
        total_items = req_q.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_cnt != total_items)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
